### rtl/core/pvs_pkg.sv
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared types and constants for the position/velocity setpoint controller.
// ----------------------------------------------------------------------------
package pvs_pkg;

   localparam int MODE_W      = 2;
   localparam int POS_W       = 32;
   localparam int LIM_W       = 31;
   localparam int CYCLE_W     = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int REQ_DATA_W  = 256;
   localparam int CNT_W       = 6;

   // request tdata layout, lowest bit first
   localparam int MAN_TGT_LSB = 0;
   localparam int MAN_VEL_LSB = MAN_TGT_LSB + POS_W;
   localparam int MAN_ACC_LSB = MAN_VEL_LSB + LIM_W;
   localparam int STU_TGT_LSB = MAN_ACC_LSB + LIM_W;
   localparam int STU_VEL_LSB = STU_TGT_LSB + POS_W;
   localparam int STU_ACC_LSB = STU_VEL_LSB + LIM_W;
   localparam int MEAS_POS_LSB = STU_ACC_LSB + LIM_W;
   localparam int MEAS_VEL_LSB = MEAS_POS_LSB + POS_W;

   localparam logic [MODE_W-1:0] MODE_MANUAL  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STANDUP = 2'd1;

   localparam logic [CSR_INDEX_W-1:0] CSR_VELOCITY_GAIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_FACTOR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CYCLE_TIME    = 2'd2;

   localparam logic [POS_W-1:0]   GAIN_RESET   = 32'd0;
   localparam logic [POS_W-1:0]   FACTOR_RESET = 32'd65536;
   localparam logic [CYCLE_W-1:0] CYCLE_RESET  = 10'd1;

   // milliseconds per second, divisor of the acceleration step
   localparam logic [CYCLE_W-1:0] MS_PER_S = 10'd1000;

   localparam logic [CNT_W-1:0] MUL_LAST = 6'd31;
   localparam logic [CNT_W-1:0] DIV_LAST = 6'd40;

   localparam logic [POS_W-1:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [POS_W-1:0] S32_MIN = 32'h8000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_VEL,
      ST_SUM,
      ST_MUL_FACTOR,
      ST_CLAMP,
      ST_MUL_ACC,
      ST_DIV,
      ST_FINAL
   } state_type;

endpackage

### rtl/core/position_velocity_setpoint.sv
// ----------------------------------------------------------------------------
// position_velocity_setpoint
// Velocity setpoint from position error and measured velocity, limited in
// magnitude and in growth per control tick. Bit-serial arithmetic.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_*     in         tuser: mode; tdata: setpoints and measurements
//  rsp_*     out        tdata: velocity_command
//  csr_*     in         index 0 gain, 1 factor, 2 CSR_CYCLE_TIME; always ready
//
//  Each item runs accept, the velocity multiply, error sum, the factor
//  multiply, clamp, the acceleration multiply (all three on one shift-add
//  unit), the restoring divide by 1000 and the result write, in that order.
//  The divider yields one quotient bit per cycle.
//  Reset clears config to defaults and the previous command to zero.
//  A result waiting in the output register holds the next item in its
//  final state until it is taken.
// ----------------------------------------------------------------------------
module position_velocity_setpoint (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // manual_target_pos, manual_vel_limit, manual_acc_limit, standup_target_pos,
   // standup_vel_limit, standup_acc_limit, measured_pos, measured_vel, pad
   input  logic [pvs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // mode
   input  logic [pvs_pkg::MODE_W-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // velocity_command
   output logic [pvs_pkg::POS_W-1:0]        rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pvs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pvs_pkg::POS_W-1:0]        csr_data
);
   import pvs_pkg::*;

   state_type state_ff, state_in;

   logic [POS_W-1:0]   gain_ff, gain_in;
   logic [POS_W-1:0]   factor_ff, factor_in;
   logic [CYCLE_W-1:0] cycle_ff, cycle_in;
   logic [POS_W-1:0]   prev_ff, prev_in;

   logic [POS_W:0]     acc_ff, acc_in;
   logic [POS_W-1:0]   mq_ff, mq_in;
   logic [POS_W-1:0]   mcand_ff, mcand_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CYCLE_W-1:0] rem_ff, rem_in;

   logic [POS_W-1:0]   tgt_ff, tgt_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LIM_W-1:0]   vlim_ff, vlim_in;
   logic [LIM_W-1:0]   alim_ff, alim_in;
   logic [POS_W-1:0]   raw_ff, raw_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]   rsp_data_ff, rsp_data_in;

   logic               req_acc;
   logic               rsp_free;
   logic               cnt_last;

   logic [POS_W+1:0]   mcand_x;
   logic [POS_W+1:0]   addend;
   logic [POS_W+1:0]   mul_sum;
   logic               prod_fits;
   logic [POS_W-1:0]   prod_sat;

   logic [POS_W+1:0]   err_wide;
   logic [POS_W-1:0]   err_sat;

   logic [POS_W:0]     raw_x;
   logic [POS_W:0]     vlim_x;
   logic [POS_W:0]     nvlim_x;
   logic [POS_W-1:0]   raw_clamped;

   logic [CYCLE_W:0]   div_t;
   logic               div_q;
   logic [CYCLE_W:0]   div_diff;

   logic [POS_W-1:0]   abs_prev;
   logic [POS_W:0]     mag;
   logic [POS_W:0]     neg_raw;
   logic [POS_W-1:0]   result;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   assign cnt_last = (state_ff == ST_DIV) ? (cnt_ff == DIV_LAST) : (cnt_ff == MUL_LAST);

   // shift-add step; the top multiplier bit carries negative weight
   assign mcand_x = {{2{mcand_ff[POS_W-1]}}, mcand_ff};
   always_comb begin
      if (mq_ff[0] && cnt_last) begin
         addend = ~mcand_x + {{(POS_W+1){1'b0}}, 1'b1};
      end else if (mq_ff[0]) begin
         addend = mcand_x;
      end else begin
         addend = '0;
      end
   end
   assign mul_sum = {acc_ff[POS_W], acc_ff} + addend;

   // product >> 16 saturated to 32 bits
   assign prod_fits = (&acc_ff[POS_W:15]) || !(|acc_ff[POS_W:15]);
   assign prod_sat  = prod_fits ? {acc_ff[15:0], mq_ff[POS_W-1:16]}
                                : (acc_ff[POS_W] ? S32_MIN : S32_MAX);

   assign err_wide = {{2{tgt_ff[POS_W-1]}}, tgt_ff} - {{2{pos_ff[POS_W-1]}}, pos_ff}
                   + {{2{prod_sat[POS_W-1]}}, prod_sat};
   assign err_sat  = ((&err_wide[POS_W+1:POS_W-1]) || !(|err_wide[POS_W+1:POS_W-1]))
                   ? err_wide[POS_W-1:0]
                   : (err_wide[POS_W+1] ? S32_MIN : S32_MAX);

   assign raw_x   = {prod_sat[POS_W-1], prod_sat};
   assign vlim_x  = {2'b00, vlim_ff};
   assign nvlim_x = ~vlim_x + {{POS_W{1'b0}}, 1'b1};
   always_comb begin
      if ($signed(raw_x) > $signed(vlim_x)) begin
         raw_clamped = vlim_x[POS_W-1:0];
      end else if ($signed(raw_x) < $signed(nvlim_x)) begin
         raw_clamped = nvlim_x[POS_W-1:0];
      end else begin
         raw_clamped = prod_sat;
      end
   end

   // restoring divide by 1000, dividend {acc[8:0], mq} shifts left
   assign div_t    = {rem_ff, acc_ff[8]};
   assign div_diff = div_t - {1'b0, MS_PER_S};
   assign div_q    = (div_t >= {1'b0, MS_PER_S});

   assign abs_prev = prev_ff[POS_W-1] ? (~prev_ff + {{(POS_W-1){1'b0}}, 1'b1}) : prev_ff;
   assign mag      = {1'b0, abs_prev} + {1'b0, mq_ff};
   assign neg_raw  = ~{raw_ff[POS_W-1], raw_ff} + {{POS_W{1'b0}}, 1'b1};
   always_comb begin
      if (!raw_ff[POS_W-1] && (|raw_ff)) begin
         result = ({1'b0, raw_ff} < mag) ? raw_ff : mag[POS_W-1:0];
      end else begin
         result = (neg_raw < mag) ? raw_ff : (~mag[POS_W-1:0] + {{(POS_W-1){1'b0}}, 1'b1});
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_acc) state_in = ST_MUL_VEL;
         ST_MUL_VEL:    if (cnt_last) state_in = ST_SUM;
         ST_SUM:        state_in = ST_MUL_FACTOR;
         ST_MUL_FACTOR: if (cnt_last) state_in = ST_CLAMP;
         ST_CLAMP:      state_in = ST_MUL_ACC;
         ST_MUL_ACC:    if (cnt_last) state_in = ST_DIV;
         ST_DIV:        if (cnt_last) state_in = ST_FINAL;
         ST_FINAL:      if (rsp_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      gain_in      = gain_ff;
      factor_in    = factor_ff;
      cycle_in     = cycle_ff;
      prev_in      = prev_ff;
      acc_in       = acc_ff;
      mq_in        = mq_ff;
      mcand_in     = mcand_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      tgt_in       = tgt_ff;
      pos_in       = pos_ff;
      vlim_in      = vlim_ff;
      alim_in      = alim_ff;
      raw_in       = raw_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VELOCITY_GAIN: gain_in   = csr_data;
            CSR_OUTPUT_FACTOR: factor_in = csr_data;
            CSR_CYCLE_TIME:    cycle_in  = csr_data[CYCLE_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               case (req_tuser)
                  MODE_MANUAL: begin
                     tgt_in  = req_tdata[MAN_TGT_LSB +: POS_W];
                     vlim_in = req_tdata[MAN_VEL_LSB +: LIM_W];
                     alim_in = req_tdata[MAN_ACC_LSB +: LIM_W];
                  end
                  MODE_STANDUP: begin
                     tgt_in  = req_tdata[STU_TGT_LSB +: POS_W];
                     vlim_in = req_tdata[STU_VEL_LSB +: LIM_W];
                     alim_in = req_tdata[STU_ACC_LSB +: LIM_W];
                  end
                  default: begin
                     tgt_in  = '0;
                     vlim_in = '0;
                     alim_in = '0;
                  end
               endcase
               pos_in   = req_tdata[MEAS_POS_LSB +: POS_W];
               mq_in    = req_tdata[MEAS_VEL_LSB +: POS_W];
               mcand_in = gain_ff;
               acc_in   = '0;
               cnt_in   = '0;
            end
         end
         ST_MUL_VEL, ST_MUL_FACTOR, ST_MUL_ACC: begin
            acc_in = mul_sum[POS_W+1:1];
            mq_in  = {mul_sum[0], mq_ff[POS_W-1:1]};
            cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
         end
         ST_SUM: begin
            mcand_in = factor_ff;
            mq_in    = err_sat;
            acc_in   = '0;
            cnt_in   = '0;
         end
         ST_CLAMP: begin
            raw_in   = raw_clamped;
            mcand_in = {1'b0, alim_ff};
            mq_in    = {{(POS_W-CYCLE_W){1'b0}}, cycle_ff};
            acc_in   = '0;
            cnt_in   = '0;
            rem_in   = '0;
         end
         ST_DIV: begin
            rem_in = div_q ? div_diff[CYCLE_W-1:0] : div_t[CYCLE_W-1:0];
            acc_in = {{(POS_W-8){1'b0}}, acc_ff[7:0], mq_ff[POS_W-1]};
            mq_in  = {mq_ff[POS_W-2:0], div_q};
            cnt_in = cnt_last ? '0 : cnt_ff + 1'b1;
         end
         ST_FINAL: begin
            if (rsp_free) begin
               prev_in      = result;
               rsp_data_in  = result;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gain_ff      <= GAIN_RESET;
         factor_ff    <= FACTOR_RESET;
         cycle_ff     <= CYCLE_RESET;
         prev_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         factor_ff    <= factor_in;
         cycle_ff     <= cycle_in;
         prev_ff      <= prev_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      mq_ff       <= mq_in;
      mcand_ff    <= mcand_in;
      rem_ff      <= rem_in;
      tgt_ff      <= tgt_in;
      pos_ff      <= pos_in;
      vlim_ff     <= vlim_in;
      alim_ff     <= alim_in;
      raw_ff      <= raw_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### tb/sv/position_velocity_setpoint_test.sv
// ----------------------------------------------------------------------------
// position_velocity_setpoint_test
// Drives setpoint items into the controller under several gain, factor and
// cycle-time settings and idle patterns. A local model of the command limiter
// predicts each velocity command, and the monitor compares the commands in
// order.
// ----------------------------------------------------------------------------
module position_velocity_setpoint_test;
   import pvs_pkg::*;

   localparam logic [MODE_W-1:0]      MODE_OFF   = 2'd2;
   localparam logic [MODE_W-1:0]      MODE_SPARE = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE  = 2'd3;
   localparam longint CMD_MAX     = 64'sd2147483647;
   localparam longint CMD_MIN     = -64'sd2147483648;
   localparam int     PHASE_ITEMS = 120;
   localparam int     HOLD_CYCLES = 1000;
   localparam int     DRAIN_CYCLES = 300;
   localparam int     CYCLE_LIMIT = 2000000;
   localparam int     PRINT_LIMIT = 40;

   typedef struct {
      logic [MODE_W-1:0]       mode;
      logic signed [POS_W-1:0] manual_target_pos;
      logic [LIM_W-1:0]        manual_vel_limit;
      logic [LIM_W-1:0]        manual_acc_limit;
      logic signed [POS_W-1:0] standup_target_pos;
      logic [LIM_W-1:0]        standup_vel_limit;
      logic [LIM_W-1:0]        standup_acc_limit;
      logic signed [POS_W-1:0] measured_pos;
      logic signed [POS_W-1:0] measured_vel;
   } setpoint_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic [MODE_W-1:0]      req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [POS_W-1:0]       rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [POS_W-1:0]       csr_data = '0;

   setpoint_item_type setpoints_pending[$];
   setpoint_item_type offered_setpoint;
   logic [POS_W-1:0]  commands_expected[$];

   longint gain_setting;
   longint factor_setting;
   longint cycle_setting;
   longint last_command;

   int  items_queued = 0;
   int  items_accepted = 0;
   int  mismatch_count = 0;
   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   int  cycle_count = 0;
   int  hold_left = 0;
   bit  hold_trigger = 1'b0;
   bit  hold_seen = 1'b0;

   position_velocity_setpoint dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint sat_command(input longint value);
      if (value > CMD_MAX) return CMD_MAX;
      if (value < CMD_MIN) return CMD_MIN;
      return value;
   endfunction

   // predicts the next command and keeps it as the previous command
   function automatic logic [POS_W-1:0] advance_command(input setpoint_item_type it);
      longint target, vel_limit, acc_limit, vel_term, err_sum, raw, acc_step, reach;
      longint cmd;
      target = 0;
      vel_limit = 0;
      acc_limit = 0;
      if (it.mode == MODE_MANUAL) begin
         target = longint'(it.manual_target_pos);
         vel_limit = longint'(it.manual_vel_limit);
         acc_limit = longint'(it.manual_acc_limit);
      end else if (it.mode == MODE_STANDUP) begin
         target = longint'(it.standup_target_pos);
         vel_limit = longint'(it.standup_vel_limit);
         acc_limit = longint'(it.standup_acc_limit);
      end
      vel_term = sat_command((gain_setting * longint'(it.measured_vel)) >>> 16);
      err_sum = sat_command(target - longint'(it.measured_pos) + vel_term);
      raw = sat_command((err_sum * factor_setting) >>> 16);
      if (raw > vel_limit) raw = vel_limit;
      if (raw < -vel_limit) raw = -vel_limit;
      acc_step = (acc_limit * cycle_setting) / 1000;
      reach = (last_command < 0 ? -last_command : last_command) + acc_step;
      if (raw > 0) cmd = (raw < reach) ? raw : reach;
      else cmd = (raw > -reach) ? raw : -reach;
      last_command = cmd;
      return cmd[POS_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what,
                  got, want);
      mismatch_count++;
   endtask

   task automatic queue_item(input logic [MODE_W-1:0] mode,
                             input logic [POS_W-1:0] man_tgt, input logic [LIM_W-1:0] man_vel,
                             input logic [LIM_W-1:0] man_acc, input logic [POS_W-1:0] stu_tgt,
                             input logic [LIM_W-1:0] stu_vel, input logic [LIM_W-1:0] stu_acc,
                             input logic [POS_W-1:0] meas_pos,
                             input logic [POS_W-1:0] meas_vel);
      setpoint_item_type it;
      it.mode = mode;
      it.manual_target_pos = man_tgt;
      it.manual_vel_limit = man_vel;
      it.manual_acc_limit = man_acc;
      it.standup_target_pos = stu_tgt;
      it.standup_vel_limit = stu_vel;
      it.standup_acc_limit = stu_acc;
      it.measured_pos = meas_pos;
      it.measured_vel = meas_vel;
      setpoints_pending.push_back(it);
      items_queued++;
   endtask

   // mostly plausible control ticks near the target, some fully random
   task automatic queue_random_item();
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  man_tgt, stu_tgt, meas_pos, meas_vel;
      logic [LIM_W-1:0]  man_vel, man_acc, stu_vel, stu_acc;
      int unsigned       pick;
      pick = $urandom_range(15);
      if (pick < 6) mode = MODE_MANUAL;
      else if (pick < 12) mode = MODE_STANDUP;
      else if (pick < 14) mode = MODE_OFF;
      else mode = MODE_SPARE;
      if ($urandom_range(3) == 0) begin
         man_tgt = $urandom;
         stu_tgt = $urandom;
         meas_pos = $urandom;
         meas_vel = $urandom;
         man_vel = LIM_W'($urandom);
         man_acc = LIM_W'($urandom);
         stu_vel = LIM_W'($urandom);
         stu_acc = LIM_W'($urandom);
      end else begin
         man_tgt = $urandom;
         stu_tgt = man_tgt + ($urandom_range(0, 1 << 22) - (1 << 21));
         meas_pos = (mode == MODE_STANDUP ? stu_tgt : man_tgt)
                    + ($urandom_range(0, 1 << 21) - (1 << 20));
         meas_vel = $urandom_range(0, 1 << 21) - (1 << 20);
         man_vel = LIM_W'($urandom_range(0, 1 << 22));
         stu_vel = LIM_W'($urandom_range(0, 1 << 22));
         man_acc = LIM_W'($urandom_range(0, 1 << 30));
         stu_acc = LIM_W'($urandom_range(0, 1 << 30));
      end
      queue_item(mode, man_tgt, man_vel, man_acc, stu_tgt, stu_vel, stu_acc, meas_pos,
                 meas_vel);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [POS_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_VELOCITY_GAIN: gain_setting = longint'($signed(value));
         CSR_OUTPUT_FACTOR: factor_setting = longint'($signed(value));
         CSR_CYCLE_TIME:    cycle_setting = longint'(value[CYCLE_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (items_accepted != items_queued || commands_expected.size() != 0);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            commands_expected.push_back(advance_command(offered_setpoint));
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (setpoints_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered_setpoint = setpoints_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= offered_setpoint.mode;
               req_tdata <= {4'b0, offered_setpoint.measured_vel, offered_setpoint.measured_pos,
                             offered_setpoint.standup_acc_limit,
                             offered_setpoint.standup_vel_limit,
                             offered_setpoint.standup_target_pos,
                             offered_setpoint.manual_acc_limit,
                             offered_setpoint.manual_vel_limit,
                             offered_setpoint.manual_target_pos};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (commands_expected.size() == 0)
               report_mismatch("unexpected velocity_command", longint'(rsp_tdata), 0);
            else if (rsp_tdata !== commands_expected[0])
               report_mismatch("velocity_command", longint'(rsp_tdata),
                               longint'(commands_expected.pop_front()));
            else
               void'(commands_expected.pop_front());
         end
         rsp_tready <= hold_left == 0 && $urandom_range(99) >= receiver_stall_pct;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int phase;
      gain_setting = longint'($signed(GAIN_RESET));
      factor_setting = longint'($signed(FACTOR_RESET));
      cycle_setting = longint'(CYCLE_RESET);
      last_command = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: unit factor, zero gain, 1 ms
      queue_item(MODE_MANUAL, 0, 0, 0, 0, 0, 0, 0, 0);
      queue_item(MODE_MANUAL, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0,
                 32'h8000_0000, 32'h7FFF_FFFF);
      queue_item(MODE_MANUAL, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0,
                 32'h8000_0000, 32'h8000_0000);
      // target equals position: zero raw command
      queue_item(MODE_MANUAL, 32'h1234_5678, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0,
                 32'h1234_5678, 0);
      queue_item(MODE_STANDUP, 0, 0, 0, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h8000_0000);
      queue_item(MODE_STANDUP, 0, 0, 0, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      // zero acceleration: magnitude cannot grow
      queue_item(MODE_STANDUP, 0, 0, 0, 32'h0100_0000, 31'h7FFF_FFFF, 0, 0, 0);
      queue_item(MODE_OFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h4000_0000, 32'hFFFF_FFFF);
      queue_item(MODE_MANUAL, 32'h0010_0000, 31'h0000_8000, 31'h7FFF_FFFF, 0, 0, 0, 0, 0);
      queue_item(MODE_SPARE, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      // zero velocity limit
      queue_item(MODE_MANUAL, 32'h7FFF_0000, 0, 31'h7FFF_FFFF, 0, 0, 0, 0, 0);
      queue_item(MODE_STANDUP, 0, 0, 0, 32'hFFF0_0000, 31'h0002_0000, 31'h0000_1000,
                 0, 0);
      queue_item(MODE_MANUAL, 32'h0001_0000, 31'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA,
                 31'h2AAA_AAAA, 31'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
      queue_item(MODE_STANDUP, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF,
                 31'h0000_0001, 31'h0000_0001, 0, 0);
      wait_drained();

      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_VELOCITY_GAIN, GAIN_RESET);
               write_register(CSR_OUTPUT_FACTOR, FACTOR_RESET);
               write_register(CSR_CYCLE_TIME, 32'(CYCLE_RESET));
               write_register(CSR_SPARE, $urandom);
            end
            1: begin
               write_register(CSR_VELOCITY_GAIN, 32'h0000_8000);
               write_register(CSR_OUTPUT_FACTOR, 32'h0002_0000);
               write_register(CSR_CYCLE_TIME, 32'd1000);
            end
            2: begin
               write_register(CSR_VELOCITY_GAIN, 32'h7FFF_FFFF);
               write_register(CSR_OUTPUT_FACTOR, 32'h8000_0000);
               write_register(CSR_CYCLE_TIME, 32'd0);
            end
            3: begin
               write_register(CSR_VELOCITY_GAIN, 32'h8000_0000);
               write_register(CSR_OUTPUT_FACTOR, 32'h7FFF_FFFF);
               write_register(CSR_CYCLE_TIME, 32'hFFFF_FFFF);
            end
            4: begin
               write_register(CSR_VELOCITY_GAIN, $urandom);
               write_register(CSR_OUTPUT_FACTOR, $urandom);
               write_register(CSR_CYCLE_TIME, $urandom_range(1, 1000));
            end
            5: begin
               write_register(CSR_VELOCITY_GAIN, $urandom_range(0, 1 << 19) - (1 << 18));
               write_register(CSR_OUTPUT_FACTOR, $urandom_range(0, 1 << 19) - (1 << 18));
               write_register(CSR_CYCLE_TIME, $urandom_range(1, 1000));
            end
            6: begin
               write_register(CSR_VELOCITY_GAIN, 32'hFFFF_0000);
               write_register(CSR_OUTPUT_FACTOR, 32'h0000_4000);
               write_register(CSR_CYCLE_TIME, 32'd1001);
            end
            7: begin
               write_register(CSR_VELOCITY_GAIN, $urandom);
               write_register(CSR_OUTPUT_FACTOR, 32'h0001_0000);
               write_register(CSR_CYCLE_TIME, 32'd500);
            end
            default: begin
               write_register(CSR_VELOCITY_GAIN, 32'h0000_0000);
               write_register(CSR_OUTPUT_FACTOR, 32'h0000_0000);
               write_register(CSR_CYCLE_TIME, 32'd1);
            end
         endcase
         case (phase % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 62; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 62; end
            default: begin sender_idle_pct = 27; receiver_stall_pct = 27; end
         endcase
         // receiver blocked while the sender keeps offering
         if (phase == 5) begin
            sender_idle_pct = 0;
            @(posedge clock);
            hold_trigger <= ~hold_trigger;
         end
         repeat (PHASE_ITEMS) queue_random_item();
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (commands_expected.size() != 0)
         report_mismatch("missing velocity_command items", 0,
                         longint'(commands_expected.size()));
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
